FILE: rtl/core/lfa_pkg.sv
// Shared types and constants for the lowest free ID allocator.
`default_nettype none
package lfa_pkg;
	localparam int TableSize = 255;
	localparam int IdBits = 8;
	localparam int ValueBits = 32;
	localparam int ChunkBits = 4;
	localparam int ChunkSize = 1 << ChunkBits;

	typedef enum logic [2:0] {
		CMD_ALLOC   = 3'd0,
		CMD_REMOVE  = 3'd1,
		CMD_FIND    = 3'd2,
		CMD_REPLACE = 3'd3,
		CMD_CLEAR   = 3'd4
	} lfa_op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ABSENT  = 2'd1,
		ST_NOSPACE = 2'd2,
		ST_INVALID = 2'd3
	} lfa_status_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic step;
		logic emit;
	} lfa_cmd_t;

	typedef struct packed {
		logic go_search;
		logic search_done;
	} lfa_stat_t;
endpackage
`default_nettype wire

FILE: rtl/core/lfa_dp.sv
// Datapath: occupancy bits, value memory, chunked free-slot search, result regs.
`default_nettype none
module lfa_dp import lfa_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lfa_cmd_t             cmd,
	output lfa_stat_t                 stat,
	input  wire logic [2:0]           in_cmd,
	input  wire logic [IdBits-1:0]    in_slot_id,
	input  wire logic [IdBits-1:0]    in_end_limit,
	input  wire logic [ValueBits-1:0] in_value,
	output logic [1:0]                res_status,
	output logic [IdBits-1:0]         res_granted_id,
	output logic [ValueBits-1:0]      res_value_out
);
	logic [TableSize-1:0] occ_q;
	logic [ValueBits-1:0] mem [TableSize];
	logic [ValueBits-1:0] rd_q;
	logic [2:0] cmd_q;
	logic [IdBits-1:0] sid_q, lim_q;
	logic [ValueBits-1:0] val_q;
	logic [IdBits-ChunkBits-1:0] chunk_q;

	logic [TableSize:0] occ_ext;
	logic sid_in_table, present;
	logic [ChunkSize-1:0] cand;
	logic hit;
	logic [ChunkBits-1:0] hit_idx;
	logic [IdBits-1:0] hit_id;
	logic last_chunk;
	logic [IdBits-1:0] next_base;
	logic wr_en;
	logic [IdBits-1:0] wr_addr;

	assign occ_ext = {1'b0, occ_q};
	assign sid_in_table = sid_q < IdBits'(TableSize);
	assign present = sid_in_table && occ_ext[sid_q];
	assign next_base = {chunk_q + 1'b1, ChunkBits'(0)};
	assign last_chunk = (chunk_q == '1) || (next_base >= lim_q);

	always_comb begin
		logic [IdBits-1:0] id;
		hit = 1'b0;
		hit_idx = '0;
		for (int b = 0; b < ChunkSize; b++) begin
			id = {chunk_q, ChunkBits'(b)};
			cand[b] = !occ_ext[id] && (id >= sid_q) && (id < lim_q);
		end
		for (int b = ChunkSize - 1; b >= 0; b--) begin
			if (cand[b]) begin
				hit = 1'b1;
				hit_idx = ChunkBits'(b);
			end
		end
	end
	assign hit_id = {chunk_q, hit_idx};

	always_comb begin
		stat.go_search = cmd.exec && (lfa_op_t'(cmd_q) == CMD_ALLOC) && (sid_q < lim_q);
		stat.search_done = cmd.step && (hit || last_chunk);
	end

	assign wr_en = (cmd.step && hit) ||
		(cmd.exec && (lfa_op_t'(cmd_q) == CMD_REPLACE) && val_q != '0 && present);
	assign wr_addr = cmd.step ? hit_id : sid_q;

	// value memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= val_q;
		if (cmd.load && in_slot_id < IdBits'(TableSize))
			rd_q <= mem[in_slot_id];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_cmd;
			sid_q <= in_slot_id;
			lim_q <= (in_end_limit == '0) ? IdBits'(TableSize) : in_end_limit;
			val_q <= in_value;
		end
		if (stat.go_search)
			chunk_q <= sid_q[IdBits-1:ChunkBits];
		else if (cmd.step)
			chunk_q <= chunk_q + 1'b1;
		if (cmd.exec) begin
			res_status <= ST_OK;
			res_granted_id <= sid_q;
			res_value_out <= '0;
			case (lfa_op_t'(cmd_q))
				CMD_ALLOC: begin
					if (!(sid_q < lim_q))
						res_status <= ST_NOSPACE;
				end
				CMD_REMOVE: begin
					if (!present)
						res_status <= ST_ABSENT;
				end
				CMD_FIND: begin
					if (!present)
						res_status <= ST_ABSENT;
					else
						res_value_out <= rd_q;
				end
				CMD_REPLACE: begin
					if (val_q == '0)
						res_status <= ST_INVALID;
					else if (!present)
						res_status <= ST_ABSENT;
					else
						res_value_out <= rd_q;
				end
				CMD_CLEAR: res_status <= ST_OK;
				default: res_status <= ST_INVALID;
			endcase
		end else if (cmd.step) begin
			if (hit)
				res_granted_id <= hit_id;
			else if (last_chunk)
				res_status <= ST_NOSPACE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cmd.exec && lfa_op_t'(cmd_q) == CMD_CLEAR) begin
			occ_q <= '0;
		end else if (cmd.exec && lfa_op_t'(cmd_q) == CMD_REMOVE && present) begin
			occ_q[sid_q] <= 1'b0;
		end else if (cmd.step && hit) begin
			occ_q[hit_id] <= 1'b1;
		end
	end

	logic unused_emit;
	assign unused_emit = cmd.emit;
endmodule
`default_nettype wire

FILE: rtl/core/lfa_ctrl.sv
// Controller: sequences accept, execute, search and result hand-off.
`default_nettype none
module lfa_ctrl import lfa_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire logic      out_free,
	input  wire lfa_stat_t stat,
	output lfa_cmd_t       cmd
);
	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SEARCH, S_DONE} state_t;
	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.load = in_ready && in_valid;
		cmd.exec = (state_q == S_EXEC);
		cmd.step = (state_q == S_SEARCH);
		cmd.emit = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_EXEC;
				S_EXEC:   state_q <= stat.go_search ? S_SEARCH : S_DONE;
				S_SEARCH: if (stat.search_done) state_q <= S_DONE;
				S_DONE:   if (out_free) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/lowest_free_id_allocator.sv
// Top level: stream ports, controller, datapath and output register.
// One command at a time. Remove, find, replace, clear and rejected commands
// need no scan; alloc scans the occupancy bits in 16-ID chunks, 16 IDs a
// cycle, from the chunk of the start ID. The next command is taken while a
// result waits in the output register.
`default_nettype none
module lowest_free_id_allocator import lfa_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [55:0] s_axis_tdata, // cmd[2:0] slot_id[10:3] end_limit[18:11] value[50:19]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata  // status[1:0] granted_id[9:2] value_out[41:10]
);
	lfa_cmd_t cmd;
	lfa_stat_t stat;
	logic out_free;
	logic [1:0] res_status;
	logic [IdBits-1:0] res_granted_id;
	logic [ValueBits-1:0] res_value_out;
	logic [41:0] out_q;

	assign out_free = !m_axis_tvalid || m_axis_tready;

	lfa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_free(out_free), .stat(stat), .cmd(cmd)
	);

	lfa_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_cmd(s_axis_tdata[2:0]), .in_slot_id(s_axis_tdata[10:3]),
		.in_end_limit(s_axis_tdata[18:11]), .in_value(s_axis_tdata[50:19]),
		.res_status(res_status), .res_granted_id(res_granted_id),
		.res_value_out(res_value_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tvalid <= 1'b0;
		else if (cmd.emit)
			m_axis_tvalid <= 1'b1;
		else if (m_axis_tready)
			m_axis_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit)
			out_q <= {res_value_out, res_granted_id, res_status};
	end

	assign m_axis_tdata = {6'd0, out_q};

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("second word accepted while a command is in flight");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result word changed while stalled");
	a_no_result_without_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result produced with no command in flight");
`endif
endmodule
`default_nettype wire

FILE: bench/tb.sv
// Testbench for the lowest free ID allocator: directed table plus random commands.
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import lfa_pkg::*;

	localparam int ClkHalf = 10;
	localparam int NumRandom = 800;

	typedef struct {
		logic [2:0]  cmd;
		logic [7:0]  slot_id;
		logic [7:0]  end_limit;
		logic [31:0] value;
		bit          fixed;      // expected word typed in below
		lfa_status_t x_status;
		logic [7:0]  x_id;
		logic [31:0] x_value;
	} dir_row_t;

	typedef struct packed {
		lfa_status_t status;
		logic [7:0]  granted_id;
		logic [31:0] value_out;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;

	// model state
	bit          slot_used [TableSize];
	logic [31:0] slot_data [TableSize];
	answer_t     pending_answers [$];
	int          fail_count;
	int          mismatch_count;
	bit          quiet_tail;

	lowest_free_id_allocator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #ClkHalf clk = ~clk;

	initial begin
		#50ms;
		$display("Test completed with failures");
		$finish;
	end

	// lowest-free scan is the plain definition; the chunked search in the block must agree
	function automatic answer_t apply_command(logic [2:0] cmd, logic [7:0] sid,
			logic [7:0] lim_in, logic [31:0] val);
		answer_t a;
		int lim;
		a.status = ST_OK;
		a.granted_id = sid;
		a.value_out = '0;
		case (cmd)
			CMD_ALLOC: begin
				lim = (lim_in == 0 || lim_in > TableSize) ? TableSize : lim_in;
				a.status = ST_NOSPACE;
				for (int i = sid; i < lim; i++) begin
					if (!slot_used[i]) begin
						slot_used[i] = 1'b1;
						slot_data[i] = val;
						a.granted_id = i[7:0];
						a.status = ST_OK;
						break;
					end
				end
			end
			CMD_REMOVE: begin
				if (sid >= TableSize || !slot_used[sid]) a.status = ST_ABSENT;
				else slot_used[sid] = 1'b0;
			end
			CMD_FIND: begin
				if (sid >= TableSize || !slot_used[sid]) a.status = ST_ABSENT;
				else a.value_out = slot_data[sid];
			end
			CMD_REPLACE: begin
				if (val == 0) a.status = ST_INVALID;
				else if (sid >= TableSize || !slot_used[sid]) a.status = ST_ABSENT;
				else begin
					a.value_out = slot_data[sid];
					slot_data[sid] = val;
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i < TableSize; i++) slot_used[i] = 1'b0;
			end
			default: a.status = ST_INVALID;
		endcase
		return a;
	endfunction

	// tvalid stays high from word to word unless an idle burst is chosen
	task automatic send_word(logic [2:0] cmd, logic [7:0] sid, logic [7:0] lim,
			logic [31:0] val, bit fixed, answer_t typed);
		answer_t a;
		if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, val, lim, sid, cmd};
		do @(posedge clk); while (!s_axis_tready);
		a = apply_command(cmd, sid, lim, val);
		if (fixed && a != typed) begin
			$display("table row disagrees with predictor: cmd %0d id %0d", cmd, sid);
			fail_count++;
		end
		pending_answers.push_back(a);
	endtask

	// random command; ids biased to at most 40 above a multiple of 32 (0 to 192)
	task automatic send_random();
		logic [2:0]  cmd;
		logic [7:0]  sid;
		logic [7:0]  lim;
		logic [31:0] val;
		answer_t     none;
		int          r;
		none = '{ST_OK, 8'd0, 32'd0};
		r = $urandom_range(0, 99);
		if (r < 40) cmd = CMD_ALLOC;
		else if (r < 60) cmd = CMD_REMOVE;
		else if (r < 78) cmd = CMD_FIND;
		else if (r < 94) cmd = CMD_REPLACE;
		else if (r < 96) cmd = CMD_CLEAR;
		else cmd = 3'($urandom_range(5, 7));
		sid = $urandom_range(0, 2) == 0 ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 40) + 32 * $urandom_range(0, 6));
		lim = $urandom_range(0, 2) == 0 ? 8'd0 : 8'($urandom_range(0, 255));
		val = $urandom_range(0, 9) == 0 ? 32'd0 : $urandom;
		send_word(cmd, sid, lim, val, 1'b0, none);
	endtask

	// result side
	always @(posedge clk) begin
		answer_t want;
		answer_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = lfa_status_t'(m_axis_tdata[1:0]);
			got.granted_id = m_axis_tdata[9:2];
			got.value_out = m_axis_tdata[41:10];
			if (pending_answers.size() == 0) begin
				fail_count++;
				if (mismatch_count++ < 10) $display("unexpected word %h", m_axis_tdata);
			end else begin
				want = pending_answers.pop_front();
				if (got != want) begin
					fail_count++;
					if (mismatch_count++ < 10)
						$display("mismatch: exp st %0d id %0d val %h, got st %0d id %0d val %h",
							want.status, want.granted_id, want.value_out,
							got.status, got.granted_id, got.value_out);
				end
			end
		end
	end

	// receiver stalls in bursts
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			if (!quiet_tail) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
	end

	initial begin
		dir_row_t rows [$];
		answer_t  typed;
		int       waited;
		fail_count = 0;
		mismatch_count = 0;
		quiet_tail = 1'b0;
		for (int i = 0; i < TableSize; i++) begin
			slot_used[i] = 1'b0;
			slot_data[i] = '0;
		end
		rows = '{
			'{CMD_FIND,    8'd0,   8'd0,   32'h0,        1, ST_ABSENT,  8'd0,   32'h0},
			'{CMD_ALLOC,   8'd0,   8'd0,   32'hFFFFFFFF, 1, ST_OK,      8'd0,   32'h0},
			'{CMD_ALLOC,   8'd0,   8'd0,   32'h0,        1, ST_OK,      8'd1,   32'h0},
			'{CMD_FIND,    8'd1,   8'd0,   32'h0,        1, ST_OK,      8'd1,   32'h0},
			'{CMD_FIND,    8'd0,   8'd0,   32'h0,        1, ST_OK,      8'd0,   32'hFFFFFFFF},
			'{CMD_ALLOC,   8'd254, 8'd0,   32'h5A5A5A5A, 1, ST_OK,      8'd254, 32'h0},
			'{CMD_ALLOC,   8'd254, 8'd255, 32'h1,        1, ST_NOSPACE, 8'd254, 32'h0},
			'{CMD_ALLOC,   8'd255, 8'd0,   32'h1,        1, ST_NOSPACE, 8'd255, 32'h0},
			'{CMD_ALLOC,   8'd10,  8'd10,  32'h1,        1, ST_NOSPACE, 8'd10,  32'h0},
			'{CMD_ALLOC,   8'd10,  8'd5,   32'h1,        1, ST_NOSPACE, 8'd10,  32'h0},
			'{CMD_ALLOC,   8'd0,   8'd2,   32'h1,        1, ST_NOSPACE, 8'd0,   32'h0},
			'{CMD_ALLOC,   8'd0,   8'd3,   32'h12345678, 1, ST_OK,      8'd2,   32'h0},
			'{CMD_REPLACE, 8'd2,   8'd0,   32'h0,        1, ST_INVALID, 8'd2,   32'h0},
			'{CMD_REPLACE, 8'd200, 8'd0,   32'h0,        1, ST_INVALID, 8'd200, 32'h0},
			'{CMD_REPLACE, 8'd2,   8'd0,   32'hCAFE0001, 1, ST_OK,      8'd2,   32'h12345678},
			'{CMD_REPLACE, 8'd255, 8'd0,   32'h1,        1, ST_ABSENT,  8'd255, 32'h0},
			'{CMD_REMOVE,  8'd1,   8'd0,   32'h0,        1, ST_OK,      8'd1,   32'h0},
			'{CMD_REMOVE,  8'd1,   8'd0,   32'h0,        1, ST_ABSENT,  8'd1,   32'h0},
			'{CMD_REMOVE,  8'd255, 8'd0,   32'h0,        1, ST_ABSENT,  8'd255, 32'h0},
			'{CMD_ALLOC,   8'd0,   8'd0,   32'h7,        1, ST_OK,      8'd1,   32'h0},
			'{3'd5,        8'd3,   8'd0,   32'h1,        1, ST_INVALID, 8'd3,   32'h0},
			'{3'd7,        8'hFF,  8'hFF,  32'hFFFFFFFF, 1, ST_INVALID, 8'hFF,  32'h0},
			'{CMD_CLEAR,   8'd0,   8'd0,   32'h0,        1, ST_OK,      8'd0,   32'h0},
			'{CMD_FIND,    8'd254, 8'd0,   32'h0,        1, ST_ABSENT,  8'd254, 32'h0},
			'{CMD_ALLOC,   8'd100, 8'd0,   32'h0,        0, ST_OK,      8'd0,   32'h0}
		};
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			typed = '{rows[i].x_status, rows[i].x_id, rows[i].x_value};
			send_word(rows[i].cmd, rows[i].slot_id, rows[i].end_limit, rows[i].value,
				rows[i].fixed, typed);
		end

		// fill the table with allocs so far searches and full-table no space happen
		for (int i = 0; i < 270; i++)
			send_word(CMD_ALLOC, 8'($urandom_range(0, 3)), 8'd0, $urandom, 1'b0, typed);

		// drain before continuing
		s_axis_tvalid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);

		for (int n = 0; n < NumRandom; n++) begin
			if (n == NumRandom - 150) quiet_tail = 1'b1;
			send_random();
		end

		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (pending_answers.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending_answers.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire
